FILE: hw/rtl/nvrw_pkg.sv
// nvrw_pkg: types, codes and constants shared by the NVMe read/write command builder.
// No dependencies; every RTL file of the block refers to it by scoped names.
`default_nettype none

package nvrw_pkg;

    // Page geometry
    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned PAGE_SHIFT = 12;

    // Default sizes handed to the top level
    localparam int unsigned LIST_ENTRIES_DEF = 32;
    localparam int unsigned DESC_DEPTH_DEF   = 2;

    // List entry count field, wide enough for the largest supported list (512)
    localparam int unsigned LIST_CNT_W = 10;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CONTROLLER_PRESENT = 3'd0,
        CFG_SECTOR_SHIFT       = 3'd1,
        CFG_MAX_SECTORS        = 3'd2,
        CFG_NAMESPACE_ID       = 3'd3,
        CFG_LIST_BASE_ADDR     = 3'd4,
        CFG_ALIAS_BASE         = 3'd5,
        CFG_ALIAS_SIZE         = 3'd6,
        CFG_QUEUE_DEPTH        = 3'd7
    } cfg_reg_e;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ARGS = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // Command opcodes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register file
    typedef struct packed {
        logic        controller_present;
        logic [3:0]  sector_shift;
        logic [16:0] max_sectors;
        logic [31:0] namespace_id;
        logic [63:0] list_base_addr;
        logic [63:0] alias_base;
        logic [63:0] alias_size;
        logic [15:0] queue_depth;
    } cfg_t;

    // Input transaction
    typedef struct packed {
        logic        is_write;
        logic [31:0] start_block;
        logic [16:0] block_count;
        logic [63:0] buffer_addr;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic        is_list_entry;
        logic [63:0] list_entry;
        logic [1:0]  opcode;
        logic [15:0] command_id;
        logic [31:0] command_namespace;
        logic [31:0] command_block;
        logic [15:0] count_minus_one;
        logic [63:0] prp_first;
        logic [63:0] prp_second;
        logic [15:0] doorbell_tail;
        logic        last;
    } out_item_t;

    // Classified request handed from front to back
    typedef struct packed {
        status_t                 status;
        logic                    is_write;
        logic [31:0]             start_block;
        logic [15:0]             count_minus_one;
        logic [63:0]             prp_first;
        logic [63:0]             prp_second;
        logic [63:0]             first_entry;
        logic [LIST_CNT_W-1:0]   n_entries;
    } desc_t;

    // Front state machine
    typedef enum logic [1:0] {
        F_IDLE,
        F_XLATE,
        F_CLASS,
        F_PUSH
    } front_state_t;

    // Back state machine
    typedef enum logic [1:0] {
        B_IDLE,
        B_LIST,
        B_CMD
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nvrw_front.sv
// nvrw_front: accepts requests, checks them, translates the buffer address and
// classifies the PRP layout into a descriptor. Depends on nvrw_pkg.
`default_nettype none

module nvrw_front #(
    parameter int unsigned LIST_ENTRIES = nvrw_pkg::LIST_ENTRIES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire nvrw_pkg::cfg_t     cfg,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire nvrw_pkg::in_item_t s_data,
    output logic                    push,
    output nvrw_pkg::desc_t         push_data,
    input  wire logic               full
);

    localparam int unsigned CW = nvrw_pkg::LIST_CNT_W;

    nvrw_pkg::front_state_t state_reg, state_next;

    nvrw_pkg::in_item_t in_reg;
    logic [63:0] off_reg;
    logic        bad_reg;
    logic [31:0] len_reg;
    logic [63:0] addr_reg;
    logic [12:0] first_reg;
    logic        over_reg;
    logic [31:0] remain_reg;

    logic        accept;
    logic [31:0] cnt_ext;
    logic [63:0] addr_c;
    logic [12:0] first_c;
    logic [63:0] page0;
    logic [32:0] round_up;
    logic [20:0] pages;
    logic        two_page;
    logic        too_long;

    assign accept = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nvrw_pkg::F_IDLE:  if (s_valid) state_next = nvrw_pkg::F_XLATE;
            nvrw_pkg::F_XLATE: state_next = nvrw_pkg::F_CLASS;
            nvrw_pkg::F_CLASS: state_next = nvrw_pkg::F_PUSH;
            nvrw_pkg::F_PUSH:  if (!full) state_next = nvrw_pkg::F_IDLE;
            default:           state_next = nvrw_pkg::F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready = 1'b0;
        push    = 1'b0;
        case (state_reg)
            nvrw_pkg::F_IDLE: s_ready = 1'b1;
            nvrw_pkg::F_PUSH: push    = !full;
            default: begin
                s_ready = 1'b0;
                push    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nvrw_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Stage 1: raw window offset, argument checks, byte length.
    // The count is 17 bits and the shift at most 15, so the length always fits 32 bits.
    assign cnt_ext = {15'd0, in_reg.block_count};

    // Stage 2: translated address and bytes left in the first page
    assign addr_c  = (off_reg < cfg.alias_size) ? off_reg : in_reg.buffer_addr;
    assign first_c = 13'(nvrw_pkg::PAGE_BYTES) - {1'b0, addr_c[11:0]};

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        if (state_reg == nvrw_pkg::F_XLATE) begin
            off_reg <= in_reg.buffer_addr - cfg.alias_base;
            bad_reg <= !cfg.controller_present || (in_reg.buffer_addr == 64'd0) ||
                       (in_reg.block_count == 17'd0) ||
                       (in_reg.block_count > cfg.max_sectors) ||
                       (cfg.queue_depth == 16'd0);
            len_reg <= cnt_ext << cfg.sector_shift;
        end
        if (state_reg == nvrw_pkg::F_CLASS) begin
            addr_reg   <= addr_c;
            first_reg  <= first_c;
            over_reg   <= len_reg > {19'd0, first_c};
            remain_reg <= len_reg - {19'd0, first_c};
        end
    end

    // Stage 3: PRP layout and descriptor
    assign page0    = addr_reg + {51'd0, first_reg};
    assign round_up = {1'b0, remain_reg} + 33'(nvrw_pkg::PAGE_BYTES - 1);
    assign pages    = round_up[32:nvrw_pkg::PAGE_SHIFT];
    assign two_page = remain_reg <= 32'(nvrw_pkg::PAGE_BYTES);
    assign too_long = pages > 21'(LIST_ENTRIES);

    always_comb begin
        push_data                 = '0;
        push_data.is_write        = in_reg.is_write;
        push_data.start_block     = in_reg.start_block;
        push_data.count_minus_one = 16'(in_reg.block_count - 17'd1);
        push_data.prp_first       = addr_reg;
        push_data.first_entry     = page0;
        push_data.status          = nvrw_pkg::ST_OK;
        if (bad_reg) begin
            push_data.status = nvrw_pkg::ST_BAD_ARGS;
        end else if (over_reg && !two_page && too_long) begin
            push_data.status = nvrw_pkg::ST_TOO_LONG;
        end
        if (!over_reg) begin
            push_data.prp_second = 64'd0;
        end else if (two_page) begin
            push_data.prp_second = page0;
        end else begin
            push_data.prp_second = cfg.list_base_addr;
            push_data.n_entries  = pages[CW-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nvrw_fifo.sv
// nvrw_fifo: short descriptor queue between the front and back sections.
// Depends on nvrw_pkg for the descriptor type.
`default_nettype none

module nvrw_fifo #(
    parameter int unsigned DEPTH = nvrw_pkg::DESC_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire nvrw_pkg::desc_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output nvrw_pkg::desc_t      pop_data,
    output logic                 empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    nvrw_pkg::desc_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic do_push, do_pop;

    assign full     = count_reg == NW'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nvrw_back.sv
// nvrw_back: emits PRP list entries and then the command (or a rejection) for each
// descriptor, and owns the submission tail. Depends on nvrw_pkg.
`default_nettype none

module nvrw_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire nvrw_pkg::cfg_t  cfg,
    output logic                 pop,
    input  wire nvrw_pkg::desc_t pop_data,
    input  wire logic            empty,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output nvrw_pkg::out_item_t  m_data
);

    localparam int unsigned CW = nvrw_pkg::LIST_CNT_W;

    nvrw_pkg::back_state_t state_reg, state_next;

    nvrw_pkg::desc_t     cur_reg;
    logic [CW-1:0]       idx_reg;
    logic [63:0]         entry_addr_reg;
    logic [15:0]         tail_reg;
    logic                m_valid_reg;
    nvrw_pkg::out_item_t m_data_reg;

    logic                out_free;
    logic                emit;
    logic [15:0]         tail_inc;
    logic [15:0]         tail_new;
    nvrw_pkg::out_item_t result;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Tail advance with wrap at the queue depth
    assign tail_inc = tail_reg + 16'd1;
    assign tail_new = (tail_inc >= cfg.queue_depth) ? 16'd0 : tail_inc;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nvrw_pkg::B_IDLE: begin
                if (!empty) begin
                    if (pop_data.status != nvrw_pkg::ST_OK || pop_data.n_entries == '0) begin
                        state_next = nvrw_pkg::B_CMD;
                    end else begin
                        state_next = nvrw_pkg::B_LIST;
                    end
                end
            end
            nvrw_pkg::B_LIST: begin
                if (out_free && idx_reg == cur_reg.n_entries - 1'b1) begin
                    state_next = nvrw_pkg::B_CMD;
                end
            end
            nvrw_pkg::B_CMD: if (out_free) state_next = nvrw_pkg::B_IDLE;
            default:          state_next = nvrw_pkg::B_IDLE;
        endcase
    end

    // Outputs: queue pop, emit strobe and result contents
    always_comb begin
        pop    = 1'b0;
        emit   = 1'b0;
        result = '0;
        case (state_reg)
            nvrw_pkg::B_IDLE: pop = !empty;
            nvrw_pkg::B_LIST: begin
                emit                 = out_free;
                result.is_list_entry = 1'b1;
                result.list_entry    = entry_addr_reg;
            end
            nvrw_pkg::B_CMD: begin
                emit        = out_free;
                result.last = 1'b1;
                if (cur_reg.status != nvrw_pkg::ST_OK) begin
                    result.status = cur_reg.status;
                end else begin
                    result.opcode            = cur_reg.is_write ? nvrw_pkg::OP_WRITE
                                                                : nvrw_pkg::OP_READ;
                    result.command_id        = tail_reg;
                    result.command_namespace = cfg.namespace_id;
                    result.command_block     = cur_reg.start_block;
                    result.count_minus_one   = cur_reg.count_minus_one;
                    result.prp_first         = cur_reg.prp_first;
                    result.prp_second        = cur_reg.prp_second;
                    result.doorbell_tail     = tail_new;
                end
            end
            default: begin
                pop    = 1'b0;
                emit   = 1'b0;
                result = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nvrw_pkg::B_IDLE;
            tail_reg    <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit && state_reg == nvrw_pkg::B_CMD && cur_reg.status == nvrw_pkg::ST_OK) begin
                tail_reg <= tail_new;
            end
        end
    end

    // Working descriptor, list walk and output register
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg        <= pop_data;
            idx_reg        <= '0;
            entry_addr_reg <= pop_data.first_entry;
        end else if (emit && state_reg == nvrw_pkg::B_LIST) begin
            idx_reg        <= idx_reg + 1'b1;
            entry_addr_reg <= entry_addr_reg + 64'(nvrw_pkg::PAGE_BYTES);
        end
        if (emit) begin
            m_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nvme_rw_command_prp_builder.sv
// NVMe read/write command builder with PRP list generation (top level).
// The four-state front section checks a request, translates its buffer address and classifies
// the PRP layout; the descriptor queue holds the result, and the back section then emits one
// result per cycle while m_ready does not stall it: n list entries followed by the command,
// n = 0..LIST_ENTRIES. The front section takes a new request only after pushing the last
// descriptor, and waits while the queue is full. Reset (aresetn low, synchronous) empties the
// queue, zeros the submission tail and loads the configuration registers with their defaults.
`default_nettype none

module nvme_rw_command_prp_builder #(
    parameter int unsigned LIST_ENTRIES = nvrw_pkg::LIST_ENTRIES_DEF,
    parameter int unsigned DESC_DEPTH   = nvrw_pkg::DESC_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    // Request channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire nvrw_pkg::in_item_t s_data,
    // Result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output nvrw_pkg::out_item_t     m_data
);

    nvrw_pkg::cfg_t  cfg_reg;
    logic            q_push, q_pop, q_full, q_empty;
    nvrw_pkg::desc_t q_push_data, q_pop_data;

    assign cfg_ready = 1'b1;

    // Configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.controller_present <= 1'b0;
            cfg_reg.sector_shift       <= 4'd9;
            cfg_reg.max_sectors        <= 17'd1;
            cfg_reg.namespace_id       <= 32'd0;
            cfg_reg.list_base_addr     <= 64'd0;
            cfg_reg.alias_base         <= 64'd0;
            cfg_reg.alias_size         <= 64'd0;
            cfg_reg.queue_depth        <= 16'd32;
        end else if (cfg_valid) begin
            case (nvrw_pkg::cfg_reg_e'(cfg_index))
                nvrw_pkg::CFG_CONTROLLER_PRESENT: cfg_reg.controller_present <= cfg_data[0];
                nvrw_pkg::CFG_SECTOR_SHIFT:       cfg_reg.sector_shift       <= cfg_data[3:0];
                nvrw_pkg::CFG_MAX_SECTORS:        cfg_reg.max_sectors        <= cfg_data[16:0];
                nvrw_pkg::CFG_NAMESPACE_ID:       cfg_reg.namespace_id       <= cfg_data[31:0];
                nvrw_pkg::CFG_LIST_BASE_ADDR:     cfg_reg.list_base_addr     <= cfg_data;
                nvrw_pkg::CFG_ALIAS_BASE:         cfg_reg.alias_base         <= cfg_data;
                nvrw_pkg::CFG_ALIAS_SIZE:         cfg_reg.alias_size         <= cfg_data;
                nvrw_pkg::CFG_QUEUE_DEPTH:        cfg_reg.queue_depth        <= cfg_data[15:0];
                default:                          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Request checking and classification
    nvrw_front #(
        .LIST_ENTRIES (LIST_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    // Descriptor queue
    nvrw_fifo #(
        .DEPTH (DESC_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // List and command emission
    nvrw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .empty    (q_empty),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for nvme_rw_command_prp_builder: a scoreboard class predicts every
// result of each accepted request, and plain tasks drive requests and register writes.
// Depends on nvrw_pkg and the RTL of nvme_rw_command_prp_builder.
`timescale 1ns / 100ps

// Predicts the submission entries and PRP list entries of each request, in order
class prp_scoreboard;
    localparam int unsigned LIST_MAX = nvrw_pkg::LIST_ENTRIES_DEF;

    nvrw_pkg::cfg_t      regs;
    logic [15:0]         sq_tail;
    nvrw_pkg::out_item_t entry_q[$];
    int                  mismatches;

    function new();
        regs              = '0;
        regs.sector_shift = 4'd9;
        regs.max_sectors  = 17'd1;
        regs.queue_depth  = 16'd32;
        sq_tail           = '0;
        mismatches        = 0;
    endfunction

    function void set_reg(nvrw_pkg::cfg_reg_e idx, logic [63:0] v);
        case (idx)
            nvrw_pkg::CFG_CONTROLLER_PRESENT: regs.controller_present = v[0];
            nvrw_pkg::CFG_SECTOR_SHIFT:       regs.sector_shift       = v[3:0];
            nvrw_pkg::CFG_MAX_SECTORS:        regs.max_sectors        = v[16:0];
            nvrw_pkg::CFG_NAMESPACE_ID:       regs.namespace_id       = v[31:0];
            nvrw_pkg::CFG_LIST_BASE_ADDR:     regs.list_base_addr     = v;
            nvrw_pkg::CFG_ALIAS_BASE:         regs.alias_base         = v;
            nvrw_pkg::CFG_ALIAS_SIZE:         regs.alias_size         = v;
            nvrw_pkg::CFG_QUEUE_DEPTH:        regs.queue_depth        = v[15:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return entry_q.size();
    endfunction

    // A rejected request yields a single result, zeroed apart from its status and the last flag
    function void push_reject(nvrw_pkg::status_t st);
        nvrw_pkg::out_item_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        entry_q.push_back(r);
    endfunction

    // Work out the results of one accepted request
    function void note_request(nvrw_pkg::in_item_t req);
        nvrw_pkg::out_item_t r;
        logic [63:0] xfer_len, off, addr, first_len, remain, prp2, n_list;
        logic [15:0] cid, nxt;
        if (!regs.controller_present || req.buffer_addr == '0 || req.block_count == '0 ||
            req.block_count > regs.max_sectors || regs.queue_depth == '0) begin
            push_reject(nvrw_pkg::ST_BAD_ARGS);
            return;
        end
        xfer_len = 64'(req.block_count) << regs.sector_shift;
        if (xfer_len > 64'hFFFF_FFFF) begin
            push_reject(nvrw_pkg::ST_BAD_ARGS);
            return;
        end
        // window test by modular offset
        off       = req.buffer_addr - regs.alias_base;
        addr      = (off < regs.alias_size) ? off : req.buffer_addr;
        first_len = 64'd4096 - {52'd0, addr[11:0]};
        prp2      = '0;
        n_list    = '0;
        if (xfer_len > first_len) begin
            remain = xfer_len - first_len;
            if (remain <= 64'd4096) begin
                prp2 = addr + first_len;
            end else begin
                n_list = (remain + 64'd4095) >> 12;
                if (n_list > 64'(LIST_MAX)) begin
                    push_reject(nvrw_pkg::ST_TOO_LONG);
                    return;
                end
                prp2 = regs.list_base_addr;
            end
        end
        for (int i = 0; i < int'(n_list); i++) begin
            r               = '0;
            r.is_list_entry = 1'b1;
            r.list_entry    = addr + first_len + (64'(i) << 12);
            entry_q.push_back(r);
        end
        cid = sq_tail;
        nxt = sq_tail + 16'd1;
        if (nxt >= regs.queue_depth) nxt = '0;
        sq_tail = nxt;
        r                   = '0;
        r.opcode            = req.is_write ? nvrw_pkg::OP_WRITE : nvrw_pkg::OP_READ;
        r.command_id        = cid;
        r.command_namespace = regs.namespace_id;
        r.command_block     = req.start_block;
        r.count_minus_one   = 16'(req.block_count - 17'd1);
        r.prp_first         = addr;
        r.prp_second        = prp2;
        r.doorbell_tail     = nxt;
        r.last              = 1'b1;
        entry_q.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(nvrw_pkg::out_item_t got);
        nvrw_pkg::out_item_t want;
        if (entry_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with nothing predicted: %h", got);
            return;
        end
        want = entry_q.pop_front();
        cmp("status", 64'(want.status), 64'(got.status));
        cmp("is_list_entry", 64'(want.is_list_entry), 64'(got.is_list_entry));
        cmp("list_entry", want.list_entry, got.list_entry);
        cmp("opcode", 64'(want.opcode), 64'(got.opcode));
        cmp("command_id", 64'(want.command_id), 64'(got.command_id));
        cmp("command_namespace", 64'(want.command_namespace), 64'(got.command_namespace));
        cmp("command_block", 64'(want.command_block), 64'(got.command_block));
        cmp("count_minus_one", 64'(want.count_minus_one), 64'(got.count_minus_one));
        cmp("prp_first", want.prp_first, got.prp_first);
        cmp("prp_second", want.prp_second, got.prp_second);
        cmp("doorbell_tail", 64'(want.doorbell_tail), 64'(got.doorbell_tail));
        cmp("last", 64'(want.last), 64'(got.last));
    endfunction
endclass

module tb_top;

    localparam int unsigned LIST_MAX   = nvrw_pkg::LIST_ENTRIES_DEF;
    localparam int          LIMIT      = 400000;
    localparam int          HOLD_LEN   = 500;
    localparam int          TAIL_WAIT  = 20;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [63:0]         cfg_data  = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    nvrw_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    nvrw_pkg::out_item_t m_data;

    prp_scoreboard sb;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_req      = 1'b0;
    bit  hold_ack      = 1'b0;
    int  hold_left     = 0;
    int  cycle_cnt     = 0;

    nvme_rw_command_prp_builder #(
        .LIST_ENTRIES(LIST_MAX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #4 aclk = ~aclk;

    // Result side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Watchdog
    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("[nvme_rw_command_prp_builder] ERROR");
        $finish;
    end

    function automatic nvrw_pkg::in_item_t mk(bit wr, logic [31:0] lba, logic [16:0] cnt,
                                              logic [63:0] buf_addr);
        nvrw_pkg::in_item_t it;
        it.is_write    = wr;
        it.start_block = lba;
        it.block_count = cnt;
        it.buffer_addr = buf_addr;
        return it;
    endfunction

    // Mostly well-formed requests sized around the list limit, some malformed
    function automatic nvrw_pkg::in_item_t gen_request();
        nvrw_pkg::in_item_t it;
        int                 sel, cap, maxs;
        logic [63:0]        b;
        maxs = int'(sb.regs.max_sectors);
        cap  = (35 * 4096) >> sb.regs.sector_shift;
        if (cap < 1) cap = 1;
        if (maxs >= 1 && cap > maxs) cap = maxs;
        b   = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 20 && sb.regs.alias_size != '0)
            b = sb.regs.alias_base + (b % sb.regs.alias_size);
        else if (sel < 35)
            b[11:0] = '0;
        else if (sel < 45)
            b[11:0] = 12'hFFF - 12'($urandom_range(0, 15));
        else if (sel < 50)
            b[63:16] = '1;
        if (b == '0) b = 64'h1000;
        it.is_write    = $urandom_range(0, 1);
        it.start_block = $urandom;
        it.buffer_addr = b;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            it.block_count = 17'($urandom_range(1, (cap < 4) ? cap : 4));
        else if (sel < 40 && maxs >= 1)
            it.block_count = 17'(maxs);
        else
            it.block_count = 17'($urandom_range(1, cap));
        // noise
        sel = $urandom_range(0, 99);
        if (sel < 4)
            it.buffer_addr = '0;
        else if (sel < 8)
            it.block_count = '0;
        else if (sel < 12 && maxs < 131071)
            it.block_count = 17'($urandom_range(maxs + 1, 131071));
        else if (sel < 16)
            it.block_count = 17'($urandom_range(0, 131071));
        return it;
    endfunction

    task automatic send_request(nvrw_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(it);
    endtask

    // Wait until every predicted result has come back
    task automatic drain();
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(nvrw_pkg::cfg_reg_e idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task automatic write_setting(bit present, logic [3:0] shift, logic [16:0] maxs,
                                 logic [31:0] ns, logic [63:0] list_base,
                                 logic [63:0] abase, logic [63:0] asize, logic [15:0] depth);
        write_reg(nvrw_pkg::CFG_CONTROLLER_PRESENT, 64'(present));
        write_reg(nvrw_pkg::CFG_SECTOR_SHIFT, 64'(shift));
        write_reg(nvrw_pkg::CFG_MAX_SECTORS, 64'(maxs));
        write_reg(nvrw_pkg::CFG_NAMESPACE_ID, 64'(ns));
        write_reg(nvrw_pkg::CFG_LIST_BASE_ADDR, list_base);
        write_reg(nvrw_pkg::CFG_ALIAS_BASE, abase);
        write_reg(nvrw_pkg::CFG_ALIAS_SIZE, asize);
        write_reg(nvrw_pkg::CFG_QUEUE_DEPTH, 64'(depth));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int n, int idle_pct, int stall, bit hold, bit mid_pause);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        if (hold) hold_req <= ~hold_req;
        for (int i = 0; i < n; i++) begin
            if (mid_pause && i == n / 2) begin
                s_valid <= 1'b0;
                drain();
            end
            send_request(gen_request());
        end
        s_valid <= 1'b0;
        drain();
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: controller absent, everything rejected
        send_request(mk(1'b1, 32'h1, 17'd1, 64'h1000));
        send_request(mk(1'b0, 32'h2, 17'd1, 64'h2000));
        s_valid <= 1'b0;
        drain();

        // Directed requests
        write_setting(1'b1, 4'd9, 17'd65536, 32'hA5A5_0001, 64'h0000_1234_5678_9000,
                      64'h8000_0000_0000_0000, 64'h0000_0000_0010_0000, 16'd32);
        send_request(mk(1'b1, 32'h0, 17'd1, 64'h0000_0000_0004_0000));     // one sector
        send_request(mk(1'b0, 32'h10, 17'd8, 64'h0000_0000_0004_0000));    // exactly a page
        send_request(mk(1'b1, 32'h11, 17'd8, 64'h0000_0000_0004_0001));    // spills to page two
        send_request(mk(1'b0, 32'h12, 17'd16, 64'h0000_0000_0004_0000));   // exactly two pages
        send_request(mk(1'b1, 32'h13, 17'd17, 64'h0000_0000_0004_0000));   // shortest list
        send_request(mk(1'b0, 32'h14, 17'd264, 64'h0000_0000_0004_0000));  // full list
        send_request(mk(1'b1, 32'h15, 17'd272, 64'h0000_0000_0004_0000));  // list too long
        send_request(mk(1'b0, 32'h16, 17'd263, 64'h0000_0000_0004_0FFF));  // too long, odd start
        send_request(mk(1'b1, 32'h17, 17'd256, 64'h0000_0000_0004_0FFF));  // long list, odd start
        send_request(mk(1'b1, 32'h18, 17'd4, 64'h0));                      // no buffer
        send_request(mk(1'b0, 32'h19, 17'd0, 64'h5000));                   // zero count
        send_request(mk(1'b1, 32'h1A, 17'd65537, 64'h5000));               // above max
        send_request(mk(1'b0, 32'h1B, 17'd65536, 64'h5000));               // max count, too long
        send_request(mk(1'b1, 32'h1C, 17'h1FFFF, 64'h5000));               // widest count
        send_request(mk(1'b0, 32'h1D, 17'd8, 64'h8000_0000_0000_0123));    // inside the window
        send_request(mk(1'b1, 32'h1E, 17'd8, 64'h8000_0000_0010_0000));    // just past the window
        send_request(mk(1'b0, 32'h1F, 17'd16, 64'hFFFF_FFFF_FFFF_F800));  // list wraps past 2^64
        send_request(mk(1'b0, 32'hFFFF_FFFF, 17'd1, 64'hFFFF_FFFF_FFFF_FFFF));
        s_valid <= 1'b0;
        drain();

        // Random phases over several settings and idle patterns
        run_phase(40, 0, 0, 1'b0, 1'b0);
        write_setting(1'b1, 4'd12, 17'd65536, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      {$urandom, $urandom}, 64'h0, 16'd65535);
        run_phase(35, 83, 0, 1'b0, 1'b0);
        // depth lowered below the current tail; window straddles address zero
        write_setting(1'b1, 4'd0, 17'h1FFFF, 32'h0, {$urandom, $urandom},
                      64'hFFFF_FFFF_FFFF_F000, 64'h2000, 16'd5);
        run_phase(35, 0, 83, 1'b1, 1'b0);
        write_setting(1'b1, 4'd15, 17'd4, $urandom, 64'h0, {$urandom, $urandom},
                      64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
        run_phase(30, 6, 6, 1'b0, 1'b0);
        write_setting(1'b1, 4'd10, 17'd1, $urandom, {$urandom, $urandom}, 64'h0,
                      64'h1_0000_0000, 16'd65535);
        run_phase(30, 0, 0, 1'b0, 1'b1);
        write_setting(1'b1, 4'd11, 17'd65536, $urandom, {$urandom, $urandom}, 64'h0,
                      64'h0, 16'd0);
        run_phase(8, 0, 83, 1'b0, 1'b0);
        write_setting(1'b0, 4'd9, 17'd0, $urandom, 64'h0, 64'h0, 64'h0, 16'd3);
        run_phase(8, 83, 0, 1'b0, 1'b0);
        write_setting(1'b1, 4'd9, 17'd65536, $urandom, {$urandom, $urandom},
                      {$urandom, $urandom}, 64'(32'($urandom)), 16'd2);
        run_phase(20, 6, 6, 1'b0, 1'b0);

        repeat (TAIL_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[nvme_rw_command_prp_builder] OK");
        else
            $display("[nvme_rw_command_prp_builder] ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/nvrw_pkg.sv
hw/rtl/nvrw_front.sv
hw/rtl/nvrw_fifo.sv
hw/rtl/nvrw_back.sv
hw/rtl/nvme_rw_command_prp_builder.sv
dv/tb_top.sv
